>>> rtl/vlfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the van Leer face reconstruction block.
// Used by van_leer_face_reconstruction and its testbench; no other dependencies.
package vlfr_pkg;

	// Field widths (signed fixed point, any binary point position)
	localparam int DATA_W     = 32;
	localparam int DIFF_W     = DATA_W + 1;      // neighbor differences
	localparam int DEN_W      = DATA_W + 1;      // |dp| + |dm|
	localparam int REM_W      = DEN_W + 1;       // partial remainder plus shifted-in bit
	localparam int SUM_W      = DATA_W + 2;      // face value before saturation

	// Quotient bits resolved per divider stage
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = DATA_W / DIV_BITS;

	// Front stages (differences, magnitudes, product) + divider + output stage
	localparam int NUM_STAGES = 3 + DIV_STAGES + 1;

	typedef struct packed {
		logic signed [DATA_W-1:0] lower_value;
		logic signed [DATA_W-1:0] centre_value;
		logic signed [DATA_W-1:0] upper_value;
	} vlfr_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] upper_face_left;
		logic signed [DATA_W-1:0] lower_face_right;
	} vlfr_out_t;

	// Clamp a widened face value to the signed data range
	function automatic logic [DATA_W-1:0] sat_data(input logic [SUM_W-1:0] v);
		logic [DATA_W-1:0] res;
		if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
			res = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			res = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

>>> rtl/van_leer_face_reconstruction.sv
`timescale 1ns / 1ps
// Top level of the van Leer limited MUSCL face reconstruction pipeline.
// Depends on vlfr_pkg for payload types, widths and the saturation helper.
//
// Usage:
//   in_valid/in_ready/in_data carry one cell (lower, centre, upper values).
//   out_valid/out_ready/out_data return the two face states of that cell.
//   cfg_wr_en/cfg_wr_data write second_order (1 = limited slope, 0 = flat).
// The pipeline has 3 front stages, 16 divider stages and 1 output stage.
// Throughput is one transaction per cycle while the receiver accepts;
// the rate is set by the restoring divider, which resolves two
// quotient bits per stage so a new cell can enter every cycle.
// Reset clears all stage valid bits and sets second_order to 1.
// When the receiver stalls, each stage holds while the one after it is
// full; empty stages keep filling, so bubbles collapse and in_ready drops
// only once every stage holds a transaction.
// The half slope is dp*dm/(dp+dm), truncated toward zero, zero when the
// differences are zero or of opposite sign; faces saturate to 32 bits.
module van_leer_face_reconstruction
	import vlfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vlfr_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output vlfr_out_t out_data,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	// Divider stage record
	typedef struct packed {
		logic [DEN_W-1:0]  rem;
		logic [DATA_W-1:0] num_lo;
		logic [DEN_W-1:0]  den;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] centre;
		logic              neg;
		logic              nz;
	} div_t;

	// One divider stage: DIV_BITS restoring steps
	function automatic div_t div_step(input div_t d);
		div_t             r;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] diff;
		logic             ge;
		r = d;
		for (int j = 0; j < DIV_BITS; j++) begin
			t        = {r.rem, r.num_lo[DATA_W-1]};
			diff     = t - {1'b0, r.den};
			ge       = (t >= {1'b0, r.den});
			r.rem    = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
			r.num_lo = {r.num_lo[DATA_W-2:0], 1'b0};
			r.quot   = {r.quot[DATA_W-2:0], ge};
		end
		return r;
	endfunction

	logic                  second_order_q;
	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] adv;

	// Stage 1: differences
	logic [DIFF_W-1:0] dm_s1, dp_s1;
	logic [DATA_W-1:0] centre_s1;
	logic              mode_s1;

	// Stage 2: magnitudes and sign
	logic [DATA_W-1:0] a_s2, b_s2, centre_s2;
	logic              neg_s2, nz_s2;

	// Stage 3: product and sum
	logic [2*DATA_W-1:0] prod_s3;
	logic [DEN_W-1:0]    den_s3;
	logic [DATA_W-1:0]   centre_s3;
	logic                neg_s3, nz_s3;

	// Divider stages (index k is pipeline stage 4+k)
	div_t div_s   [DIV_STAGES];
	div_t div_nxt [DIV_STAGES];
	div_t div_seed;

	// Output stage
	vlfr_out_t out_s20;

	logic [DIFF_W-1:0] dp_mag, dm_mag;
	logic [SUM_W-1:0]  c_plus_q, c_minus_q, face_up, face_dn;
	div_t              div_last;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_order_q <= 1'b1;
		end else if (cfg_wr_en) begin
			second_order_q <= cfg_wr_data;
		end
	end

	// Stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		adv[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = stage_vld_q[NUM_STAGES-1];
	assign out_data  = out_s20;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: backward and forward differences
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dm_s1     <= {in_data.centre_value[DATA_W-1], in_data.centre_value}
			           - {in_data.lower_value[DATA_W-1], in_data.lower_value};
			dp_s1     <= {in_data.upper_value[DATA_W-1], in_data.upper_value}
			           - {in_data.centre_value[DATA_W-1], in_data.centre_value};
			centre_s1 <= in_data.centre_value;
			mode_s1   <= second_order_q;
		end
	end

	// Stage 2: magnitudes, common sign, nonzero-slope flag
	always_comb begin
		dp_mag = dp_s1[DIFF_W-1] ? (~dp_s1 + 1'b1) : dp_s1;
		dm_mag = dp_s1[DIFF_W-1] ? (~dm_s1 + 1'b1) : dm_s1;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			a_s2      <= dp_mag[DATA_W-1:0];
			b_s2      <= dm_mag[DATA_W-1:0];
			neg_s2    <= dp_s1[DIFF_W-1];
			nz_s2     <= mode_s1 && (dp_s1 != '0) && (dm_s1 != '0)
			             && (dp_s1[DIFF_W-1] == dm_s1[DIFF_W-1]);
			centre_s2 <= centre_s1;
		end
	end

	// Stage 3: numerator |dp|*|dm| and denominator |dp|+|dm|
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			prod_s3   <= a_s2 * b_s2;
			den_s3    <= {1'b0, a_s2} + {1'b0, b_s2};
			centre_s3 <= centre_s2;
			neg_s3    <= neg_s2;
			nz_s3     <= nz_s2;
		end
	end

	// Divider: the quotient never exceeds min(|dp|,|dm|), so the upper half
	// of the numerator is already below the denominator
	always_comb begin
		div_seed.rem    = {1'b0, prod_s3[2*DATA_W-1:DATA_W]};
		div_seed.num_lo = prod_s3[DATA_W-1:0];
		div_seed.den    = den_s3;
		div_seed.quot   = '0;
		div_seed.centre = centre_s3;
		div_seed.neg    = neg_s3;
		div_seed.nz     = nz_s3;
		div_nxt[0]      = div_step(div_seed);
		for (int k = 1; k < DIV_STAGES; k++) begin
			div_nxt[k] = div_step(div_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (adv[3+k]) begin
				div_s[k] <= div_nxt[k];
			end
		end
	end

	// Output stage: apply the sign, offset the centre, saturate
	always_comb begin
		div_last  = div_s[DIV_STAGES-1];
		c_plus_q  = {{2{div_last.centre[DATA_W-1]}}, div_last.centre}
		          + {2'b00, div_last.nz ? div_last.quot : {DATA_W{1'b0}}};
		c_minus_q = {{2{div_last.centre[DATA_W-1]}}, div_last.centre}
		          - {2'b00, div_last.nz ? div_last.quot : {DATA_W{1'b0}}};
		face_up   = div_last.neg ? c_minus_q : c_plus_q;
		face_dn   = div_last.neg ? c_plus_q : c_minus_q;
	end

	always_ff @(posedge clk) begin
		if (adv[NUM_STAGES-1]) begin
			out_s20.upper_face_left  <= sat_data(face_up);
			out_s20.lower_face_right <= sat_data(face_dn);
		end
	end

endmodule

>>> bench/tb_van_leer_face_reconstruction.sv
`timescale 1ns / 1ps
// Testbench for van_leer_face_reconstruction: random and corner-case cells,
// face states predicted per cell and checked in order. Depends on vlfr_pkg.
module tb_van_leer_face_reconstruction;
	import vlfr_pkg::*;

	localparam logic [DATA_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_NEG_MAX = 32'h8000_0000;

	// Predicts the two face states of each accepted cell and checks results in order
	class face_scoreboard;
		vlfr_out_t faces_q[$];
		bit        limited;   // mirror of second_order
		int        errors;

		function new();
			limited = 1'b1;
			errors  = 0;
		endfunction

		// Clamp a 64-bit face value into the signed 32-bit range
		function logic signed [DATA_W-1:0] clamp_face(input longint v);
			if (v > 64'sd2147483647) begin
				return Q_POS_MAX;
			end
			if (v < -64'sd2147483648) begin
				return Q_NEG_MAX;
			end
			return v[DATA_W-1:0];
		endfunction

		function void note_cell(input vlfr_in_t vals);
			longint          lo, mid, up, dm, dp, half;
			longint unsigned mag_p, mag_m, quo;
			vlfr_out_t       res;
			lo   = longint'(vals.lower_value);
			mid  = longint'(vals.centre_value);
			up   = longint'(vals.upper_value);
			dm   = mid - lo;
			dp   = up - mid;
			half = 0;
			// Limited half slope: dp*dm/(dp+dm), only for same-sign nonzero differences
			if (limited && dm != 0 && dp != 0 && ((dm < 0) == (dp < 0))) begin
				mag_p = (dp < 0) ? -dp : dp;
				mag_m = (dm < 0) ? -dm : dm;
				quo   = (mag_p * mag_m) / (mag_p + mag_m);
				half  = (dp < 0) ? -longint'(quo) : longint'(quo);
			end
			res.upper_face_left  = clamp_face(mid + half);
			res.lower_face_right = clamp_face(mid - half);
			faces_q.push_back(res);
		endfunction

		function void check_faces(input vlfr_out_t got);
			vlfr_out_t want;
			if (faces_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result %h/%h", got.upper_face_left,
						got.lower_face_right);
				end
				return;
			end
			want = faces_q.pop_front();
			if (got.upper_face_left !== want.upper_face_left ||
				got.lower_face_right !== want.lower_face_right) begin
				errors++;
				if (errors <= 10) begin
					$display("face mismatch: expected %h/%h got %h/%h",
						want.upper_face_left, want.lower_face_right,
						got.upper_face_left, got.lower_face_right);
				end
			end
		endfunction

		function bit busy();
			return faces_q.size() != 0;
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	vlfr_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	vlfr_out_t out_data;
	logic      cfg_wr_en;
	logic      cfg_wr_data;

	face_scoreboard faces = new();
	bit             quiet;   // no idling on either side while set

	van_leer_face_reconstruction uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic vlfr_in_t cell_of(input logic [DATA_W-1:0] lo, mid, up);
		vlfr_in_t vals;
		vals.lower_value  = lo;
		vals.centre_value = mid;
		vals.upper_value  = up;
		return vals;
	endfunction

	// Random cell: mostly smooth monotone data, plus extrema, flat spots and noise
	function automatic vlfr_in_t make_cell();
		logic [DATA_W-1:0] mid, dm, dp;
		int                kind;
		kind = $urandom_range(0, 99);
		mid  = $signed($urandom) >>> $urandom_range(0, 8);
		dm   = $urandom >> $urandom_range(0, 31);
		dp   = $urandom >> $urandom_range(0, 31);
		if (kind < 15) begin
			return cell_of($urandom, $urandom, $urandom);
		end
		if (kind < 45) begin
			return cell_of(mid - dm, mid, mid + dp);
		end
		if (kind < 75) begin
			return cell_of(mid + dm, mid, mid - dp);
		end
		if (kind < 88) begin
			// local extremum: differences of opposite sign
			if ($urandom_range(0, 1)) begin
				return cell_of(mid - dm, mid, mid - dp);
			end
			return cell_of(mid + dm, mid, mid + dp);
		end
		// one difference zero
		if ($urandom_range(0, 1)) begin
			return cell_of(mid, mid, mid + dp);
		end
		return cell_of(mid - dm, mid, mid);
	endfunction

	// One input transaction; valid stays high across back-to-back cells
	task automatic send_cell(input vlfr_in_t vals);
		int n;
		n = pick_gap(quiet);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= vals;
		do @(posedge clk); while (!in_ready);
		faces.note_cell(vals);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (faces.busy());
	endtask

	task automatic write_mode(input bit second_order);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= second_order;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		faces.limited = second_order;
	endtask

	// Corner cells: range extremes, opposite and zero differences, truncation
	task automatic send_corners();
		send_cell(cell_of(32'h0, 32'h0, 32'h0));
		send_cell(cell_of(Q_NEG_MAX, 32'h0, Q_POS_MAX));
		send_cell(cell_of(Q_POS_MAX, 32'h0, Q_NEG_MAX));
		send_cell(cell_of(Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX));
		send_cell(cell_of(Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX));
		send_cell(cell_of(Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX));
		send_cell(cell_of(Q_POS_MAX, Q_POS_MAX, Q_POS_MAX));
		send_cell(cell_of(Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX));
		send_cell(cell_of(Q_NEG_MAX, Q_POS_MAX, Q_POS_MAX));
		send_cell(cell_of(32'd0, 32'd1, 32'd3));
		send_cell(cell_of(32'd0, -32'sd1, -32'sd3));
		send_cell(cell_of(-32'sd65536, 32'd0, 32'd65536));
		send_cell(cell_of(32'h0001_0000, 32'h0003_0000, 32'h0007_0000));
		send_cell(cell_of(32'd5, 32'd3, 32'd1));
		send_cell(cell_of(32'h8000_0001, 32'hC000_0000, Q_POS_MAX));
		send_cell(cell_of(32'd3, 32'd3, 32'd7));
		send_cell(cell_of(32'hFFFF_FFFF, 32'h0, 32'h1));
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			faces.check_faces(out_data);
		end
	end

	// Receiver: random backpressure
	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap(quiet);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Main sequence
	initial begin
		bit phase_mode[6];
		phase_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(1'b1);
		send_corners();
		drain();

		for (int p = 0; p < 6; p++) begin
			write_mode(phase_mode[p]);
			quiet = (p == 2);
			repeat (305) send_cell(make_cell());
			drain();
		end
		quiet = 1'b0;

		repeat (25) @(posedge clk);
		if (faces.errors == 0 && !faces.busy()) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
